[src/bsr_pkg.sv]
// shared types, constants and control store for the bisection square root block
package bsr_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned FracW       = 16;
  localparam int unsigned SquareW     = 2 * DataW;
  localparam int unsigned CountW      = 7;
  localparam logic [CountW-1:0] MaxHalvings  = CountW'(48);
  localparam logic [DataW-1:0]  OneQ16       = DataW'(32'h0001_0000);
  localparam logic [DataW-1:0]  TolResetVal  = DataW'(65);

  typedef logic [1:0] step_t;

  localparam step_t StepIdle   = 2'd0;
  localparam step_t StepSquare = 2'd1;
  localparam step_t StepTest   = 2'd2;
  localparam step_t StepDone   = 2'd3;

  // jump conditions, taken when true, otherwise fall through to the next step
  typedef enum logic [1:0] {
    CondNoInBeat     = 2'd0,
    CondSpecial      = 2'd1,
    CondNotFinished  = 2'd2,
    CondOutStalled   = 2'd3
  } cond_e;

  typedef struct packed {
    logic  accept;
    logic  square;
    logic  test;
    logic  deliver;
    cond_e cond;
    step_t target;
  } uword_t;

  // datapath strobes
  typedef struct packed {
    logic load;
    logic square;
    logic test;
  } dp_ctrl_t;

  // datapath flags for the jump logic
  typedef struct packed {
    logic special;
    logic finished;
  } dp_status_t;

  // control store: one word per step
  function automatic uword_t ucode_rom(input step_t step);
    uword_t uw;
    uw = '0;
    unique case (step)
      StepIdle: begin
        uw.accept = 1'b1;
        uw.cond   = CondNoInBeat;
        uw.target = StepIdle;
      end
      StepSquare: begin
        uw.square = 1'b1;
        uw.cond   = CondSpecial;
        uw.target = StepDone;
      end
      StepTest: begin
        uw.test   = 1'b1;
        uw.cond   = CondNotFinished;
        uw.target = StepSquare;
      end
      StepDone: begin
        uw.deliver = 1'b1;
        uw.cond    = CondOutStalled;
        uw.target  = StepDone;
      end
      default: begin
        uw = '0;
      end
    endcase
    return uw;
  endfunction

endpackage

[src/bsr_datapath.sv]
// interval registers, squaring unit and tolerance test of the bisection root
module bsr_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bsr_pkg::dp_ctrl_t               ctrl_i,
  input  logic [bsr_pkg::DataW-1:0]       value_i,
  input  logic [bsr_pkg::DataW-1:0]       tolerance_i,
  output bsr_pkg::dp_status_t             status_o,
  output logic [bsr_pkg::DataW-1:0]       root_o,
  output logic [bsr_pkg::CountW-1:0]      halvings_o,
  output logic                            capped_o
);
  import bsr_pkg::*;

  logic [DataW-1:0]   v_q, lo_q, hi_q, x_q;
  logic [DataW-1:0]   lo_d, hi_d, x_d;
  logic [SquareW-1:0] sq_q;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic               cap_q, cap_d;
  logic               special_q, finished_q, finished_d;

  logic [DataW-1:0]   hi_init;
  logic               is_zero, is_one;
  logic [SquareW-1:0] val64, tol64, diff;
  logic               sq_gt, in_tol;
  logic [DataW:0]     sum_lo, sum_hi;

  assign is_zero = (value_i == '0);
  assign is_one  = (value_i == OneQ16);
  assign hi_init = (value_i > OneQ16) ? value_i : OneQ16;

  assign val64 = {{(SquareW-DataW-FracW){1'b0}}, v_q, {FracW{1'b0}}};
  assign tol64 = {{(SquareW-DataW-FracW){1'b0}}, tolerance_i, {FracW{1'b0}}};
  assign sq_gt  = (sq_q > val64);
  assign diff   = sq_gt ? (sq_q - val64) : (val64 - sq_q);
  assign in_tol = (diff <= tol64);

  // both possible next midpoints, picked after the compare
  assign sum_lo = {1'b0, lo_q} + {1'b0, x_q};
  assign sum_hi = {1'b0, x_q} + {1'b0, hi_q};

  always_comb begin
    lo_d       = lo_q;
    hi_d       = hi_q;
    x_d        = x_q;
    cnt_d      = cnt_q;
    cap_d      = cap_q;
    finished_d = finished_q;
    if (ctrl_i.load) begin
      lo_d       = '0;
      hi_d       = hi_init;
      cnt_d      = '0;
      cap_d      = 1'b0;
      finished_d = 1'b0;
      if (is_zero) begin
        x_d = '0;
      end else if (is_one) begin
        x_d = OneQ16;
      end else begin
        x_d = {1'b0, hi_init[DataW-1:1]};
      end
    end else if (ctrl_i.test) begin
      if (in_tol) begin
        finished_d = 1'b1;
      end else if (cnt_q >= MaxHalvings) begin
        finished_d = 1'b1;
        cap_d      = 1'b1;
      end else begin
        cnt_d = cnt_q + CountW'(1);
        if (sq_gt) begin
          hi_d = x_q;
          x_d  = sum_lo[DataW:1];
        end else begin
          lo_d = x_q;
          x_d  = sum_hi[DataW:1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      special_q  <= 1'b0;
      finished_q <= 1'b0;
    end else begin
      if (ctrl_i.load) begin
        special_q <= is_zero | is_one;
      end
      finished_q <= finished_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      v_q <= value_i;
    end
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    x_q   <= x_d;
    cnt_q <= cnt_d;
    cap_q <= cap_d;
    if (ctrl_i.square) begin
      sq_q <= x_q * x_q;
    end
  end

  // finished_d is what the test step decides this cycle
  assign status_o.special  = special_q;
  assign status_o.finished = finished_d;

  assign root_o     = x_q;
  assign halvings_o = cnt_q;
  assign capped_o   = cap_q;

endmodule

[src/bisection_square_root_top.sv]
// top level of the bisection square root: control store sequencer and config register
// steps: idle, square and test until finished, then done; zero or one skip the test
// throughput: one item at a time, next input taken the cycle after the result beat
// each halving runs a square step then a test step, up to 48 halvings
// reset: asynchronous active low, tolerance returns to 65 and the sequencer to idle
module bisection_square_root_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         tolerance_we_i,
  input  logic [bsr_pkg::DataW-1:0]    tolerance_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bsr_pkg::DataW-1:0]    value_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bsr_pkg::DataW-1:0]    root_o,
  output logic [bsr_pkg::CountW-1:0]   halvings_o,
  output logic                         capped_o
);
  import bsr_pkg::*;

  step_t      pc_q, pc_d;
  uword_t     uw;
  logic       jump;
  dp_ctrl_t   dp_ctrl;
  dp_status_t dp_status;
  logic [DataW-1:0] tol_q;

  // tolerance register; write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolResetVal;
    end else if (tolerance_we_i) begin
      tol_q <= tolerance_i;
    end
  end

  // current control word
  assign uw = ucode_rom(pc_q);

  // jump condition select
  always_comb begin
    unique case (uw.cond)
      CondNoInBeat:    jump = !in_valid_i;
      CondSpecial:     jump = dp_status.special;
      CondNotFinished: jump = !dp_status.finished;
      CondOutStalled:  jump = out_stall_i;
      default:         jump = 1'b0;
    endcase
  end

  // step counter: jump to target or fall through, wrapping from done to idle
  assign pc_d = jump ? uw.target : pc_q + step_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  // handshake: ready only in the idle step, result held in the done step
  assign in_stall_o  = !uw.accept;
  assign out_valid_o = uw.deliver;

  assign dp_ctrl.load   = uw.accept & in_valid_i;
  assign dp_ctrl.square = uw.square;
  assign dp_ctrl.test   = uw.test;

  bsr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (dp_ctrl),
    .value_i     (value_i),
    .tolerance_i (tol_q),
    .status_o    (dp_status),
    .root_o      (root_o),
    .halvings_o  (halvings_o),
    .capped_o    (capped_o)
  );

endmodule

[dv/bsr_checker.sv]
// checker for the bisection square root: predicts each result and compares it
`timescale 1ns / 1ps

module bsr_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tolerance_we_i,
  input  logic [bsr_pkg::DataW-1:0]   tolerance_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [bsr_pkg::DataW-1:0]   value_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [bsr_pkg::DataW-1:0]   root_i,
  input  logic [bsr_pkg::CountW-1:0]  halvings_i,
  input  logic                        capped_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);

  import bsr_pkg::*;

  localparam int unsigned MaxReports = 40;

  typedef struct packed {
    logic [DataW-1:0]  root;
    logic [CountW-1:0] halvings;
    logic              capped;
  } sqrt_result_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    sqrt_result_t     res;
  } root_due_t;

  root_due_t        roots_due_q[$];
  logic [DataW-1:0] tol_q;

  // interval halving on [0, max(1.0, value)], square kept exact in Q32.32
  function automatic sqrt_result_t bisect_sqrt(input logic [DataW-1:0] value,
                                               input logic [DataW-1:0] tol);
    logic [SquareW-1:0] target, margin, lo, hi, mid, sq, diff;
    logic [CountW-1:0]  count;
    logic               done;
    sqrt_result_t       r;
    target   = {16'b0, value, 16'b0};
    margin   = {16'b0, tol, 16'b0};
    lo       = '0;
    hi       = (value > OneQ16) ? SquareW'(value) : SquareW'(OneQ16);
    mid      = (lo + hi) >> 1;
    count    = '0;
    r.capped = 1'b0;
    if (value == '0) begin
      mid = '0;
    end else if (value == OneQ16) begin
      mid = SquareW'(OneQ16);
    end else begin
      done = 1'b0;
      while (!done) begin
        sq   = mid * mid;
        diff = (sq >= target) ? (sq - target) : (target - sq);
        if (diff <= margin) begin
          done = 1'b1;
        end else if (count >= MaxHalvings) begin
          r.capped = 1'b1;
          done     = 1'b1;
        end else begin
          if (sq > target) hi = mid;
          else lo = mid;
          mid   = (lo + hi) >> 1;
          count = count + 1'b1;
        end
      end
    end
    r.root     = mid[DataW-1:0];
    r.halvings = count;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sqrt_result_t got;
    root_due_t    due;
    int unsigned  errs;
    if (!rst_ni) begin
      roots_due_q.delete();
      tol_q        <= TolResetVal;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      errs = 0;
      // result side first: a result leaving now belongs to an earlier beat
      if (out_valid_i && !out_stall_i) begin
        got.root     = root_i;
        got.halvings = halvings_i;
        got.capped   = capped_i;
        if (roots_due_q.size() == 0) begin
          errs++;
          if (fail_count_o < MaxReports)
            $display("%0t: unexpected result beat: expected none, actual root %h halvings %0d capped %b",
                     $time, got.root, got.halvings, got.capped);
        end else begin
          due = roots_due_q.pop_front();
          if (due.res !== got) begin
            errs++;
            if (fail_count_o < MaxReports)
              $display("%0t: value %h: expected root %h halvings %0d capped %b, actual root %h halvings %0d capped %b",
                       $time, due.value, due.res.root, due.res.halvings, due.res.capped,
                       got.root, got.halvings, got.capped);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        roots_due_q.push_back({value_i, bisect_sqrt(value_i, tol_q)});
      if (tolerance_we_i) tol_q <= tolerance_i;
      fail_count_o <= fail_count_o + errs;
      pending_o    <= roots_due_q.size();
    end
  end

endmodule

[dv/tb_bisection_square_root_top.sv]
// testbench top for the bisection square root: stimulus, stalls, watchdog and verdict
`timescale 1ns / 1ps

module tb_bisection_square_root_top;

  import bsr_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;  // covers the slowest item plus two bursts
  localparam int unsigned PhaseItems    = 100;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned DrainCycles   = 110;   // a bit over the longest latency

  logic              clk_i;
  logic              rst_ni;
  logic              tolerance_we_q;
  logic [DataW-1:0]  tolerance_q;
  logic              in_valid_q;
  logic [DataW-1:0]  value_q;
  logic              out_stall_q;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [DataW-1:0]  root_o;
  logic [CountW-1:0] halvings_o;
  logic              capped_o;
  int unsigned       fail_count;
  int unsigned       pending;

  bit          idle_on;      // random idling on both sides while set
  int unsigned items_sent;
  int unsigned tol_writes;

  // free running clock, 12 ns period
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  bisection_square_root_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tolerance_we_i (tolerance_we_q),
    .tolerance_i    (tolerance_q),
    .in_valid_i     (in_valid_q),
    .in_stall_o     (in_stall_o),
    .value_i        (value_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_q),
    .root_o         (root_o),
    .halvings_o     (halvings_o),
    .capped_o       (capped_o)
  );

  bsr_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tolerance_we_i (tolerance_we_q),
    .tolerance_i    (tolerance_q),
    .in_valid_i     (in_valid_q),
    .in_stall_i     (in_stall_o),
    .value_i        (value_q),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_q),
    .root_i         (root_o),
    .halvings_i     (halvings_o),
    .capped_i       (capped_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // receiver side: random stall bursts while idling is on, mixed with free stretches
  initial begin
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall_q <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_stall_q <= 1'b0;
        // now and then a long stretch with no stall at all
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 80)) @(posedge clk_i);
        else repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
    end
  end

  // hang detection: any cycle without a beat on either channel counts
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_q && !in_stall_o) || (out_valid_o && !out_stall_q)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog, no beat for %0d cycles", $time, WatchdogLimit);
    $display("FAIL");
    $finish;
  end

  // one input beat; valid stays high after the beat so back-to-back beats never drop it
  task automatic send_value(input logic [DataW-1:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_q <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_q <= 1'b1;
    value_q    <= v;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // drop valid and wait until every predicted root has come out
  task automatic drain;
    in_valid_q <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // register write, only called with the block idle
  task automatic set_tolerance(input logic [DataW-1:0] t);
    tolerance_we_q <= 1'b1;
    tolerance_q    <= t;
    @(posedge clk_i);
    tolerance_we_q <= 1'b0;
    tol_writes++;
  endtask

  // value mix: full range, near one, small, exact squares, wide dynamic range, near the top
  function automatic logic [DataW-1:0] pick_value();
    logic [DataW-1:0] n;
    case ($urandom_range(0, 9))
      0, 1:    pick_value = $urandom();
      2:       pick_value = $urandom_range(0, 32'h0001_ffff);
      3:       pick_value = OneQ16 + $urandom_range(0, 64) - 32;
      4: begin
        n          = $urandom_range(0, 255);
        pick_value = (n * n) << FracW;
      end
      5, 6:    pick_value = $urandom() >> $urandom_range(0, 31);
      7:       pick_value = $urandom_range(0, 15);
      8:       pick_value = 32'hffff_ffff - $urandom_range(0, 255);
      default: begin
        // the two values answered at once, and the top of the range
        case ($urandom_range(0, 2))
          0:       pick_value = '0;
          1:       pick_value = OneQ16;
          default: pick_value = 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [DataW-1:0] tol;
    idle_on        = 1'b1;
    items_sent     = 0;
    tol_writes     = 0;
    rst_ni         <= 1'b0;
    tolerance_we_q <= 1'b0;
    tolerance_q    <= '0;
    in_valid_q     <= 1'b0;
    value_q        <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset tolerance: zero, exactly one, extremes, values around one
    send_value('0);
    send_value(OneQ16);
    send_value(32'hffff_ffff);
    send_value(32'h0000_0001);
    send_value(32'h0000_ffff);
    send_value(32'h0001_0001);
    send_value(32'h0002_0000);
    send_value(32'h0004_0000);
    send_value(32'h0009_0000);
    send_value(32'h8000_0000);
    send_value(32'h7fff_ffff);
    send_value(32'h0000_0100);
    drain();

    // zero tolerance: the cap is hit unless the midpoint lands exactly
    set_tolerance('0);
    send_value(32'h0002_0000);
    send_value(32'h0004_0000);
    send_value(32'hffff_ffff);
    send_value(32'h0000_0001);
    send_value('0);
    drain();

    // widest tolerance: small values pass at the first midpoint, large ones still halve
    set_tolerance(32'hffff_ffff);
    send_value(32'h0002_0000);
    send_value(32'h1234_5678);
    send_value(32'hffff_ffff);
    drain();

    // random phases, each under its own tolerance; the last one runs without idling
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:       tol = TolResetVal;
        1:       tol = '0;
        2:       tol = 32'hffff_ffff;
        3:       tol = 32'h0000_0001;
        4:       tol = $urandom_range(0, 32'h0000_0fff);
        5:       tol = OneQ16;
        default: tol = $urandom();
      endcase
      idle_on = (phase != NumPhases - 1);
      set_tolerance(tol);
      for (int unsigned i = 0; i < PhaseItems; i++) send_value(pick_value());
      drain();
    end

    // let any stray result show up before the verdict
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d values under %0d tolerance writes, including zero and all ones",
             items_sent, tol_writes);
    $display("stall and gap bursts on both channels, a final phase at full rate");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pending);
      $display("FAIL");
    end
    $finish;
  end

endmodule
